/* hdl/aoq_pkg.sv */
package aoq_pkg;

    localparam int SAMPLE_W = 32;
    localparam int WORD_W   = 32;
    localparam int PCM_W    = 16;
    localparam int RES_W    = 8;
    localparam int OFF_W    = 16;
    localparam int ACC_W    = 16;
    localparam int BLEN_W   = 13;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W   = OFF_W + BLEN_W;
    localparam int DECAY_SH = 15;

    localparam logic [1:0] MODE_I2S  = 2'd0;
    localparam logic [1:0] MODE_DAC  = 2'd1;
    localparam logic [1:0] MODE_BUZZ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO_OUT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAC_ZERO_LEVEL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LENGTH  = 2'd3;

    localparam logic [BLEN_W-1:0] BLEN_RESET = 13'd256;
    localparam logic [OFF_W-1:0]  OFFSET_CAP = 16'd32767;
    localparam logic [PCM_W-1:0]  PCM_MAX    = 16'h7FFF;
    localparam logic [PCM_W-1:0]  PCM_MIN    = 16'h8000;
    localparam logic [PCM_W-1:0]  CODE_MAX   = 16'hFFFF;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [OFF_W-1:0]    offset;
        logic [RES_W-1:0]    residue;
        logic [BLEN_W-1:0]   len;
        logic                dac;
        logic                track;
        logic                start;
    } t_quant_in;

    typedef struct packed {
        logic [PCM_W-1:0] word;
        logic [RES_W-1:0] residue;
        logic [OFF_W-1:0] offset;
    } t_quant_out;

endpackage

/* hdl/aoq_in_if.sv */
interface aoq_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample;
    logic        lane;
    logic        buffer_start;

    modport source (output valid, output sample, output lane, output buffer_start,
                    input ready);
    modport sink (input valid, input sample, input lane, input buffer_start,
                  output ready);
endinterface

/* hdl/aoq_out_if.sv */
interface aoq_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_word;
    logic        out_lane;

    modport source (output valid, output out_word, output out_lane, input ready);
    modport sink (input valid, input out_word, input out_lane, output ready);
endinterface

/* hdl/aoq_quant.sv */
module aoq_quant (
    input  aoq_pkg::t_quant_in  i_q,
    output aoq_pkg::t_quant_out o_q
);
    import aoq_pkg::*;

    logic [PROD_W-1:0]   prod;
    logic [OFF_W-1:0]    off_dec;
    logic [OFF_W-1:0]    off_new;
    logic [SAMPLE_W-1:0] mag;
    logic [SAMPLE_W+1:0] v_dac;
    logic [SAMPLE_W:0]   v_pcm;
    logic [SAMPLE_W-8:0] q_pcm;
    logic [PCM_W-1:0]    pcm_word;
    logic [PCM_W-1:0]    dac_word;

    always_comb begin
        prod    = PROD_W'(i_q.offset) * PROD_W'(i_q.len);
        off_dec = i_q.offset;
        if (i_q.track && i_q.start) begin
            off_dec = i_q.offset - OFF_W'(prod[PROD_W-1:DECAY_SH]);
        end

        mag = i_q.sample[SAMPLE_W-1] ? (~i_q.sample + 32'd1) : i_q.sample;
        off_new = off_dec;
        if (i_q.track && ({16'd0, off_dec} < mag)) begin
            off_new = (mag > {16'd0, OFFSET_CAP}) ? OFFSET_CAP : mag[OFF_W-1:0];
        end

        v_dac = {{2{i_q.sample[SAMPLE_W-1]}}, i_q.sample} + {18'd0, off_new}
              + {26'd0, i_q.residue};
        if (v_dac[SAMPLE_W+1]) begin
            dac_word = '0;
        end else if (|v_dac[SAMPLE_W:PCM_W]) begin
            dac_word = CODE_MAX;
        end else begin
            dac_word = v_dac[PCM_W-1:0];
        end

        v_pcm = {i_q.sample[SAMPLE_W-1], i_q.sample} + {25'd0, i_q.residue};
        q_pcm = v_pcm[SAMPLE_W:8];
        if ((&q_pcm[SAMPLE_W-8:PCM_W-1]) || !(|q_pcm[SAMPLE_W-8:PCM_W-1])) begin
            pcm_word = q_pcm[PCM_W-1:0];
        end else if (q_pcm[SAMPLE_W-8]) begin
            pcm_word = PCM_MIN;
        end else begin
            pcm_word = PCM_MAX;
        end

        o_q.offset = off_new;
        if (i_q.dac) begin
            o_q.word    = dac_word;
            o_q.residue = v_dac[RES_W-1:0];
        end else begin
            o_q.word    = pcm_word;
            o_q.residue = v_pcm[RES_W-1:0];
        end
    end

endmodule

/* hdl/aoq_sigma.sv */
module aoq_sigma (
    input  logic [aoq_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [aoq_pkg::ACC_W-1:0]    i_acc,
    output logic [aoq_pkg::WORD_W-1:0]   o_bits,
    output logic [aoq_pkg::ACC_W-1:0]    o_acc
);
    import aoq_pkg::*;

    logic [PCM_W-1:0] ss;
    logic [ACC_W-1:0] u;
    logic [22:0]      t [WORD_W+1];

    // acc after k steps is (acc - k*u) mod 2^16; a bit is set where the
    // upper part of the running difference drops
    always_comb begin
        if ((&i_sample[SAMPLE_W-1:PCM_W-1]) || !(|i_sample[SAMPLE_W-1:PCM_W-1])) begin
            ss = i_sample[PCM_W-1:0];
        end else if (i_sample[SAMPLE_W-1]) begin
            ss = PCM_MIN;
        end else begin
            ss = PCM_MAX;
        end
        u = {~ss[PCM_W-1], ss[PCM_W-2:0]};
        for (int k = 0; k <= WORD_W; k++) begin
            t[k] = {7'd0, i_acc} - (23'(k) * {7'd0, u});
        end
        for (int k = 1; k <= WORD_W; k++) begin
            o_bits[WORD_W-k] = (t[k-1][22:16] != t[k][22:16]);
        end
        o_acc = t[WORD_W][ACC_W-1:0];
    end

endmodule

/* hdl/audio_output_quantizer.sv */
// Data path: an accepted item is held in the input register, then moves to the result register that drives the output.
// Throughput: one item per cycle; the input register and the result register
// each advance every cycle while the output side takes items.
// Reset (synchronous, active low): empties both registers, clears residues,
// offset and delta-sigma accumulator, and loads register reset values.
module audio_output_quantizer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [aoq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [aoq_pkg::CFG_W-1:0]       i_cfg_data,
    aoq_in_if.sink                          i_in,
    aoq_out_if.source                       o_out
);
    import aoq_pkg::*;

    logic [1:0]          r_mode;
    logic                r_stereo;
    logic [7:0]          r_zero;
    logic [BLEN_W-1:0]   r_blen;

    logic [RES_W-1:0]    r_res [2];
    logic [OFF_W-1:0]    r_off;
    logic [ACC_W-1:0]    r_acc;

    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_lane;
    logic                r_start;

    logic                r_out_valid;
    logic [WORD_W-1:0]   r_word;
    logic                r_olane;

    logic                advance;
    logic                ridx;
    logic                is_dac;
    logic                is_buzz;
    t_quant_in           q_in;
    t_quant_out          q_out;
    logic [WORD_W-1:0]   sig_bits;
    logic [ACC_W-1:0]    sig_acc;
    logic [WORD_W-1:0]   n_word;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.out_word = r_word;
    assign o_out.out_lane = r_olane;

    assign ridx    = r_lane & r_stereo;
    assign is_dac  = (r_mode == MODE_DAC);
    assign is_buzz = (r_mode == MODE_BUZZ);

    always_comb begin
        q_in.sample  = r_sample;
        q_in.offset  = r_off;
        q_in.residue = r_res[ridx];
        q_in.len     = {r_blen[BLEN_W-1:1], 1'b0};
        q_in.dac     = is_dac;
        q_in.track   = is_dac && (r_zero == 8'd0);
        q_in.start   = r_start;
    end

    aoq_quant u_quant (
        .i_q (q_in),
        .o_q (q_out)
    );

    aoq_sigma u_sigma (
        .i_sample (r_sample),
        .i_acc    (r_acc),
        .o_bits   (sig_bits),
        .o_acc    (sig_acc)
    );

    assign n_word = is_buzz ? sig_bits : {16'd0, q_out.word};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_I2S;
            r_stereo    <= 1'b0;
            r_zero      <= 8'd0;
            r_blen      <= BLEN_RESET;
            r_res[0]    <= '0;
            r_res[1]    <= '0;
            r_off       <= '0;
            r_acc       <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_OUTPUT_MODE:    r_mode   <= i_cfg_data[1:0];
                    REG_STEREO_OUT:     r_stereo <= i_cfg_data[0];
                    REG_DAC_ZERO_LEVEL: r_zero   <= i_cfg_data[7:0];
                    REG_BUFFER_LENGTH:  r_blen   <= i_cfg_data[BLEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cfg_we && (i_cfg_index == REG_DAC_ZERO_LEVEL)) begin
                r_off <= {i_cfg_data[7:0], 8'h00};
            end else if (advance && is_dac) begin
                r_off <= q_out.offset;
            end
            if (advance) begin
                if (is_buzz) begin
                    r_acc <= sig_acc;
                end else begin
                    r_res[ridx] <= q_out.residue;
                end
            end
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_sample <= i_in.sample;
            r_lane   <= i_in.lane;
            r_start  <= i_in.buffer_start;
        end
        if (advance) begin
            r_word  <= n_word;
            r_olane <= r_lane;
        end
    end

    a_offset_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_zero == 8'd0) |-> (r_off <= OFFSET_CAP))
        else $error("offset above cap while tracking");

    a_buzz_keeps_residue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_buzz) |=> ($stable(r_res[0]) && $stable(r_res[1])))
        else $error("residue changed in buzzer mode");

    a_lane_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out_valid && (r_olane == $past(r_lane))))
        else $error("result lost or lane mismatch");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> (!r_in_valid || advance))
        else $error("input register overwritten");

endmodule
